### hw/rtl/lpht_pkg.sv
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int KEY_MAX_BYTES = 8;
    localparam int KEY_W         = 64;
    localparam int LEN_W         = 4;
    localparam int MODE_W        = 3;
    localparam int STATUS_W      = 2;
    localparam int IDX_W         = 3;
    localparam int HASH_W        = 32;

    // Remainder bits retired per cycle by the bucket reduction.
    localparam int MOD_STEP   = 4;
    localparam int MOD_CYCLES = HASH_W / MOD_STEP;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

    localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FIND       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ERASE_CLR  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ERASE_TOMB = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_USED  = 2'd1,
        TAG_TOMB  = 2'd2
    } tag_t;

    typedef struct packed {
        tag_t             tag;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
    } slot_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        H_IDLE,
        H_BYTES,
        H_MOD
    } hstate_t;

endpackage

### hw/rtl/linear_probe_hash_table.sv
`timescale 1ns / 1ps

// Channel  Direction  Signals                          Word contents (lowest bit first)
// s_       in         s_tvalid s_tready s_tuser s_tdata  tuser: mode; tdata: key bytes, length
// m_       out        m_tvalid m_tready m_tdata          tdata: status, slot index
//
// One operation is in flight at a time. Insert, find and both erase modes run the hash over
// the key bytes and the bucket reduction, wait until the bucket rotates to the head of the
// slot ring, probe one slot per ring step (at most SLOTS probes) and then load the output
// register. Clear all and unknown modes skip the hash and the probe. After reset all slots
// read empty at once. A stalled result waits in the output register while the ring keeps
// turning; the next word is taken once the result has been moved to that register.
module linear_probe_hash_table #(
    parameter int SLOTS = lpht_pkg::SLOTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // mode
    input  logic [71:0] s_tdata,   // key_bytes [63:0], key_length [67:64], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // status [1:0], slot_index [4:2], zero pad
);

    localparam int RW = $clog2(SLOTS);

    lpht_pkg::state_t                  state_reg;
    lpht_pkg::state_t                  state_next;
    logic [lpht_pkg::KEY_W-1:0]        key_reg;
    logic [lpht_pkg::LEN_W-1:0]        len_reg;
    logic [lpht_pkg::MODE_W-1:0]       mode_reg;
    logic [RW-1:0]                     head_reg;
    logic [RW-1:0]                     head_next;
    logic [RW-1:0]                     steps_reg;
    logic [RW-1:0]                     steps_next;
    logic [lpht_pkg::STATUS_W-1:0]     res_status_reg;
    logic [lpht_pkg::STATUS_W-1:0]     res_status_next;
    logic [lpht_pkg::IDX_W-1:0]        res_idx_reg;
    logic [lpht_pkg::IDX_W-1:0]        res_idx_next;
    logic                              m_tvalid_reg;
    logic [7:0]                        m_tdata_reg;

    logic                              accept;
    logic [lpht_pkg::LEN_W-1:0]        in_len;
    logic [lpht_pkg::KEY_W-1:0]        in_key;
    logic                              hash_start;
    logic                              hash_done;
    logic [RW-1:0]                     hash_bucket;
    logic                              clear_all;
    logic                              instant_done;
    logic                              probe_done;
    logic                              wr_en;
    lpht_pkg::slot_t                   wr_slot;
    lpht_pkg::slot_t                   feed;
    lpht_pkg::slot_t                   ring [SLOTS];
    lpht_pkg::slot_t                   cur;
    logic                              probe_active;
    logic                              probe_last;
    logic                              key_match;
    logic                              out_free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == lpht_pkg::S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // Lengths above the maximum saturate; bytes at or above the length are dropped.
    assign in_len = (s_tdata[67:64] > lpht_pkg::LEN_W'(lpht_pkg::KEY_MAX_BYTES))
                  ? lpht_pkg::LEN_W'(lpht_pkg::KEY_MAX_BYTES) : s_tdata[67:64];

    always_comb
    begin
        for (int b = 0; b < lpht_pkg::KEY_MAX_BYTES; b++)
        begin
            in_key[8*b +: 8] = (lpht_pkg::LEN_W'(b) < in_len) ? s_tdata[8*b +: 8] : 8'd0;
        end
    end

    lpht_hash #(
        .SLOTS (SLOTS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (in_key),
        .len    (in_len),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    // The slot ring turns by one every cycle: cell i holds slot (head + i) mod SLOTS.
    // Cell 0 is the probe point; a write replaces the word that leaves cell 0.
    assign feed = wr_en ? wr_slot : ring[0];

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        lpht_pkg::slot_t cell_d;
        if (i == SLOTS - 1)
        begin : g_tail
            assign cell_d = feed;
        end
        else
        begin : g_mid
            assign cell_d = ring[i + 1];
        end
        lpht_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .clear (clear_all),
            .d     (cell_d),
            .q     (ring[i])
        );
    end

    assign head_next = (head_reg == RW'(SLOTS - 1)) ? '0 : head_reg + 1'b1;

    assign cur          = ring[0];
    assign key_match    = (cur.tag == lpht_pkg::TAG_USED) && (cur.len == len_reg)
                       && (cur.key == key_reg);
    assign probe_active = (state_reg == lpht_pkg::S_PROBE)
                       && ((steps_reg != '0) || (head_reg == hash_bucket));
    assign probe_last   = (steps_reg == RW'(SLOTS - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpht_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = instant_done ? lpht_pkg::S_DONE : lpht_pkg::S_HASH;
                end
            end
            lpht_pkg::S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = lpht_pkg::S_PROBE;
                end
            end
            lpht_pkg::S_PROBE:
            begin
                if (probe_done)
                begin
                    state_next = lpht_pkg::S_DONE;
                end
            end
            lpht_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = lpht_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lpht_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the controller: mode decode on accept, probe decisions at cell 0.
    always_comb
    begin
        hash_start      = 1'b0;
        clear_all       = 1'b0;
        instant_done    = 1'b0;
        probe_done      = 1'b0;
        wr_en           = 1'b0;
        wr_slot         = cur;
        steps_next      = steps_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        unique case (state_reg)
            lpht_pkg::S_IDLE:
            begin
                steps_next = '0;
                if (accept)
                begin
                    unique case (s_tuser) inside
                        lpht_pkg::MODE_INSERT, lpht_pkg::MODE_FIND,
                        lpht_pkg::MODE_ERASE_CLR, lpht_pkg::MODE_ERASE_TOMB:
                        begin
                            hash_start = 1'b1;
                        end
                        lpht_pkg::MODE_CLEAR:
                        begin
                            clear_all       = 1'b1;
                            instant_done    = 1'b1;
                            res_status_next = lpht_pkg::ST_OK;
                            res_idx_next    = '0;
                        end
                        default:
                        begin
                            instant_done    = 1'b1;
                            res_status_next = lpht_pkg::ST_MISS;
                            res_idx_next    = '0;
                        end
                    endcase
                end
            end
            lpht_pkg::S_PROBE:
            begin
                if (probe_active)
                begin
                    steps_next = steps_reg + 1'b1;
                    if (mode_reg == lpht_pkg::MODE_INSERT)
                    begin
                        if (cur.tag != lpht_pkg::TAG_USED)
                        begin
                            probe_done      = 1'b1;
                            wr_en           = 1'b1;
                            wr_slot.tag     = lpht_pkg::TAG_USED;
                            wr_slot.key     = key_reg;
                            wr_slot.len     = len_reg;
                            res_status_next = lpht_pkg::ST_OK;
                            res_idx_next    = lpht_pkg::IDX_W'(head_reg);
                        end
                        else if (probe_last)
                        begin
                            probe_done      = 1'b1;
                            res_status_next = lpht_pkg::ST_FULL;
                            res_idx_next    = '0;
                        end
                    end
                    else
                    begin
                        if (cur.tag == lpht_pkg::TAG_EMPTY)
                        begin
                            probe_done      = 1'b1;
                            res_status_next = lpht_pkg::ST_MISS;
                            res_idx_next    = '0;
                        end
                        else if (key_match)
                        begin
                            probe_done      = 1'b1;
                            res_status_next = lpht_pkg::ST_OK;
                            res_idx_next    = lpht_pkg::IDX_W'(head_reg);
                            if (mode_reg == lpht_pkg::MODE_ERASE_CLR)
                            begin
                                wr_en       = 1'b1;
                                wr_slot.tag = lpht_pkg::TAG_EMPTY;
                            end
                            else if (mode_reg == lpht_pkg::MODE_ERASE_TOMB)
                            begin
                                wr_en       = 1'b1;
                                wr_slot.tag = lpht_pkg::TAG_TOMB;
                            end
                        end
                        else if (probe_last)
                        begin
                            probe_done      = 1'b1;
                            res_status_next = lpht_pkg::ST_MISS;
                            res_idx_next    = '0;
                        end
                    end
                end
            end
            default:
            begin
                steps_next = steps_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lpht_pkg::S_IDLE;
            head_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            if ((state_reg == lpht_pkg::S_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg  <= in_key;
            len_reg  <= in_len;
            mode_reg <= s_tuser;
        end
        steps_reg      <= steps_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        if ((state_reg == lpht_pkg::S_DONE) && out_free)
        begin
            m_tdata_reg <= {3'd0, res_idx_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### hw/rtl/lpht_cell.sv
`timescale 1ns / 1ps

// One slot of the rotating ring. It takes its neighbor's slot every cycle.
module lpht_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  lpht_pkg::slot_t d,
    output lpht_pkg::slot_t q
);

    lpht_pkg::tag_t                 tag_reg;
    lpht_pkg::tag_t                 tag_next;
    logic [lpht_pkg::KEY_W-1:0]     key_reg;
    logic [lpht_pkg::LEN_W-1:0]     len_reg;

    always_comb
    begin
        tag_next = clear ? lpht_pkg::TAG_EMPTY : d.tag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= lpht_pkg::TAG_EMPTY;
        end
        else
        begin
            tag_reg <= tag_next;
        end
    end

    // Key and length are only read behind a used tag, so they need no reset.
    always_ff @(posedge clk)
    begin
        key_reg <= d.key;
        len_reg <= d.len;
    end

    assign q.tag = tag_reg;
    assign q.key = key_reg;
    assign q.len = len_reg;

endmodule

### hw/rtl/lpht_hash.sv
`timescale 1ns / 1ps

// Byte-serial FNV-1a hash followed by a radix-16 restoring reduction modulo SLOTS.
module lpht_hash #(
    parameter int SLOTS = lpht_pkg::SLOTS_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lpht_pkg::KEY_W-1:0] key,
    input  logic [lpht_pkg::LEN_W-1:0] len,
    output logic                       done,
    output logic [$clog2(SLOTS)-1:0]   bucket
);

    localparam int RW = $clog2(SLOTS);
    localparam int MW = $clog2(lpht_pkg::MOD_CYCLES);
    localparam logic [RW:0] SLOTS_C = (RW + 1)'(SLOTS);

    lpht_pkg::hstate_t                state_reg;
    lpht_pkg::hstate_t                state_next;
    logic [lpht_pkg::HASH_W-1:0]      h_reg;
    logic [lpht_pkg::HASH_W-1:0]      h_next;
    logic [lpht_pkg::KEY_W-1:0]       ksh_reg;
    logic [lpht_pkg::KEY_W-1:0]       ksh_next;
    logic [lpht_pkg::LEN_W-1:0]       cnt_reg;
    logic [lpht_pkg::LEN_W-1:0]       cnt_next;
    logic [lpht_pkg::LEN_W-1:0]       len_reg;
    logic [lpht_pkg::LEN_W-1:0]       len_next;
    logic [MW-1:0]                    mcnt_reg;
    logic [MW-1:0]                    mcnt_next;
    logic [RW:0]                      rem_reg;
    logic [RW:0]                      rem_next;
    logic [RW-1:0]                    bucket_reg;
    logic [RW-1:0]                    bucket_next;
    logic                             done_reg;
    logic                             done_next;
    logic [lpht_pkg::HASH_W-1:0]      h_mul;
    logic [RW:0]                      rem_step;
    logic [lpht_pkg::HASH_W-1:0]      h_shift;
    logic                             bytes_left;
    logic                             mod_last;

    assign bytes_left = (cnt_reg != len_reg);
    assign mod_last   = (mcnt_reg == MW'(lpht_pkg::MOD_CYCLES - 1));
    assign h_mul      = (h_reg ^ {24'd0, ksh_reg[7:0]}) * lpht_pkg::FNV_PRIME;

    always_comb
    begin
        logic [RW:0]                 rv;
        logic [lpht_pkg::HASH_W-1:0] hv;
        rv = rem_reg;
        hv = h_reg;
        for (int j = 0; j < lpht_pkg::MOD_STEP; j++)
        begin
            rv = {rv[RW-1:0], hv[lpht_pkg::HASH_W-1]};
            hv = {hv[lpht_pkg::HASH_W-2:0], 1'b0};
            if (rv >= SLOTS_C)
            begin
                rv = rv - SLOTS_C;
            end
        end
        rem_step = rv;
        h_shift  = hv;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpht_pkg::H_IDLE:
            begin
                if (start)
                begin
                    state_next = lpht_pkg::H_BYTES;
                end
            end
            lpht_pkg::H_BYTES:
            begin
                if (!bytes_left)
                begin
                    state_next = lpht_pkg::H_MOD;
                end
            end
            lpht_pkg::H_MOD:
            begin
                if (mod_last)
                begin
                    state_next = lpht_pkg::H_IDLE;
                end
            end
            default:
            begin
                state_next = lpht_pkg::H_IDLE;
            end
        endcase
    end

    always_comb
    begin
        h_next      = h_reg;
        ksh_next    = ksh_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        mcnt_next   = mcnt_reg;
        rem_next    = rem_reg;
        bucket_next = bucket_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            lpht_pkg::H_IDLE:
            begin
                if (start)
                begin
                    h_next   = lpht_pkg::FNV_BASIS;
                    ksh_next = key;
                    len_next = len;
                    cnt_next = '0;
                end
            end
            lpht_pkg::H_BYTES:
            begin
                if (bytes_left)
                begin
                    h_next   = h_mul;
                    ksh_next = {8'd0, ksh_reg[lpht_pkg::KEY_W-1:8]};
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    mcnt_next = '0;
                    rem_next  = '0;
                end
            end
            lpht_pkg::H_MOD:
            begin
                h_next    = h_shift;
                rem_next  = rem_step;
                mcnt_next = mcnt_reg + 1'b1;
                if (mod_last)
                begin
                    bucket_next = rem_step[RW-1:0];
                    done_next   = 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpht_pkg::H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg      <= h_next;
        ksh_reg    <= ksh_next;
        cnt_reg    <= cnt_next;
        len_reg    <= len_next;
        mcnt_reg   <= mcnt_next;
        rem_reg    <= rem_next;
        bucket_reg <= bucket_next;
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;

endmodule

### hw/rtl/lpht_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the hash table.
module lpht_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic [71:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // A failed operation never reports a slot.
    a_fail_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] != 2'd0)) |-> (m_tdata[4:2] == 3'd0))
        else $error("nonzero status with nonzero slot index");

    // Status code three is never produced.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("undefined status code");

    // Only one operation is taken at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while an operation is in flight");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // A waiting input word holds until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tuser) && $stable(s_tdata)))
        else $error("waiting input word changed");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### verif/linear_probe_hash_table_test.sv
`timescale 1ns / 1ps

module linear_probe_hash_table_test;

    localparam int SLOTS       = 8;
    localparam int POOL_KEYS   = 12;
    localparam int RANDOM_OPS  = 1850;
    localparam int SEGMENT_OPS = 150;
    localparam int DRAIN_LIMIT = 20000;
    // Longest operation: eight hash bytes, the bucket reduction, a full ring
    // rotation and eight probes. The tail wait is comfortably above that.
    localparam int TAIL_CYCLES = 64;

    // One result word as it sits in m_tdata, status in the lowest bits.
    typedef struct packed {
        logic [lpht_pkg::IDX_W-1:0]    slot;
        logic [lpht_pkg::STATUS_W-1:0] status;
    } table_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [2:0]  s_tuser = '0;    // mode
    logic [71:0] s_tdata = '0;    // key_bytes [63:0], key_length [67:64], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // status [1:0], slot_index [4:2], zero pad

    // Shadow copy of the slot store, updated in acceptance order.
    lpht_pkg::tag_t             shadow_tag [SLOTS];
    logic [lpht_pkg::KEY_W-1:0] shadow_key [SLOTS];
    logic [lpht_pkg::LEN_W-1:0] shadow_len [SLOTS];

    table_result_t expected_results[$];
    int            mismatch_count = 0;

    // Idle controls shared by the tests and the two handshake sides.
    bit sender_no_idle   = 1'b0;
    bit receiver_no_idle = 1'b0;
    int hold_off_cycles  = 0;

    linear_probe_hash_table #(
        .SLOTS(SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Mask that keeps the bytes below the effective key length.
    function automatic logic [lpht_pkg::KEY_W-1:0] key_mask(input int len);
        if (len >= lpht_pkg::KEY_MAX_BYTES)
            return '1;
        return (64'd1 << (8 * len)) - 64'd1;
    endfunction

    // FNV-1a over the valid key bytes, byte 0 first, reduced to a bucket.
    function automatic int unsigned fnv1a_bucket(input logic [lpht_pkg::KEY_W-1:0] key,
            input int len);
        logic [lpht_pkg::HASH_W-1:0] h;
        h = lpht_pkg::FNV_BASIS;
        for (int i = 0; i < len; i++)
        begin
            h = h ^ {24'd0, key[8*i +: 8]};
            h = h * lpht_pkg::FNV_PRIME;
        end
        return h % SLOTS;
    endfunction

    // Applies one accepted operation to the shadow store and queues the
    // result word that the block must return for it.
    function automatic void apply_operation(input logic [lpht_pkg::MODE_W-1:0] mode,
            input logic [lpht_pkg::KEY_W-1:0] raw_key,
            input logic [lpht_pkg::LEN_W-1:0] raw_len);
        int                         len;
        int                         pos;
        int                         hit;
        bit                         stop;
        logic [lpht_pkg::KEY_W-1:0] key;
        table_result_t              res;
        len  = (raw_len > lpht_pkg::KEY_MAX_BYTES) ? lpht_pkg::KEY_MAX_BYTES : int'(raw_len);
        key  = raw_key & key_mask(len);
        pos  = fnv1a_bucket(key, len);
        hit  = -1;
        stop = 1'b0;
        res.status = lpht_pkg::ST_MISS;
        res.slot   = '0;
        case (mode)
            lpht_pkg::MODE_INSERT:
            begin
                // No duplicate check: the first free or tombstone slot wins.
                res.status = lpht_pkg::ST_FULL;
                for (int n = 0; n < SLOTS; n++)
                begin
                    if (hit < 0 && shadow_tag[pos] != lpht_pkg::TAG_USED)
                        hit = pos;
                    pos = (pos + 1) % SLOTS;
                end
                if (hit >= 0)
                begin
                    shadow_tag[hit] = lpht_pkg::TAG_USED;
                    shadow_key[hit] = key;
                    shadow_len[hit] = len[lpht_pkg::LEN_W-1:0];
                    res.status = lpht_pkg::ST_OK;
                    res.slot   = hit[lpht_pkg::IDX_W-1:0];
                end
            end
            lpht_pkg::MODE_FIND, lpht_pkg::MODE_ERASE_CLR, lpht_pkg::MODE_ERASE_TOMB:
            begin
                // Probe walks past tombstones and stops at the first empty slot.
                for (int n = 0; n < SLOTS; n++)
                begin
                    if (hit < 0 && !stop)
                    begin
                        if (shadow_tag[pos] == lpht_pkg::TAG_EMPTY)
                            stop = 1'b1;
                        else if (shadow_tag[pos] == lpht_pkg::TAG_USED
                                 && int'(shadow_len[pos]) == len
                                 && shadow_key[pos] == key)
                            hit = pos;
                    end
                    pos = (pos + 1) % SLOTS;
                end
                if (hit >= 0)
                begin
                    res.status = lpht_pkg::ST_OK;
                    res.slot   = hit[lpht_pkg::IDX_W-1:0];
                    if (mode == lpht_pkg::MODE_ERASE_CLR)
                        shadow_tag[hit] = lpht_pkg::TAG_EMPTY;
                    else if (mode == lpht_pkg::MODE_ERASE_TOMB)
                        shadow_tag[hit] = lpht_pkg::TAG_TOMB;
                end
            end
            lpht_pkg::MODE_CLEAR:
            begin
                for (int n = 0; n < SLOTS; n++)
                    shadow_tag[n] = lpht_pkg::TAG_EMPTY;
                res.status = lpht_pkg::ST_OK;
            end
            default: ;
        endcase
        expected_results.push_back(res);
    endfunction

    // A want value of -1 marks a word that arrived with nothing pending.
    function automatic void note_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t ns: %s expected %0d got %0d", $time, what, want, got);
    endfunction

    // Offers one operation word after a random gap and waits for the block to
    // take it. The prediction is made at the accepting edge, so the shadow
    // store follows exactly the order in which the block sees the words.
    task automatic offer_operation(input logic [lpht_pkg::MODE_W-1:0] mode,
            input logic [lpht_pkg::KEY_W-1:0] key, input logic [lpht_pkg::LEN_W-1:0] len);
        int gap;
        gap = sender_no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'd0, len, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_operation(mode, key, len);
    endtask

    // Lookups and erases on an empty table all miss, as do the unused modes.
    task automatic test_empty_table();
        offer_operation(lpht_pkg::MODE_FIND, 64'h0000_0000_0000_1234, 4'd2);
        offer_operation(lpht_pkg::MODE_ERASE_TOMB, 64'h0000_0000_0000_1234, 4'd2);
        for (int m = 5; m < 8; m++)
            offer_operation(m[lpht_pkg::MODE_W-1:0], {$urandom, $urandom},
                            4'($urandom_range(0, 15)));
    endtask

    // The empty key, stray bytes above the length, and a length field above
    // the key width that must act like the full eight bytes.
    task automatic test_key_extremes();
        offer_operation(lpht_pkg::MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
        offer_operation(lpht_pkg::MODE_FIND, 64'hA5A5_0000_5A5A_1111, 4'd0);
        offer_operation(lpht_pkg::MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        // Same key again through the saturating length: a second copy lands
        // in the next free slot because insert does not look for duplicates.
        offer_operation(lpht_pkg::MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        offer_operation(lpht_pkg::MODE_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd12);
    endtask

    // Fills every slot, overflows, then works with tombstones and clearing.
    task automatic test_fill_and_full();
        offer_operation(lpht_pkg::MODE_CLEAR, '0, '0);
        for (int k = 1; k <= SLOTS; k++)
            offer_operation(lpht_pkg::MODE_INSERT, 64'(k), 4'd1);
        offer_operation(lpht_pkg::MODE_INSERT, 64'(SLOTS + 1), 4'd1);
        offer_operation(lpht_pkg::MODE_ERASE_TOMB, 64'd3, 4'd1);
        offer_operation(lpht_pkg::MODE_FIND, 64'(SLOTS), 4'd1);
        offer_operation(lpht_pkg::MODE_INSERT, 64'(SLOTS + 1), 4'd1);
        offer_operation(lpht_pkg::MODE_ERASE_CLR, 64'd5, 4'd1);
        offer_operation(lpht_pkg::MODE_CLEAR, '0, '0);
    endtask

    // The receiver holds off for a long stretch while words keep coming, so
    // the output register fills and the block has to refuse input.
    task automatic test_output_backpressure();
        hold_off_cycles = 400;
        sender_no_idle  = 1'b1;
        for (int k = 0; k < 12; k++)
            offer_operation((k < 6) ? lpht_pkg::MODE_INSERT : lpht_pkg::MODE_FIND,
                            64'(k * 64'h0101), 4'd2);
        sender_no_idle = 1'b0;
    endtask

    // Mostly well-formed traffic over a small pool of keys, so that finds
    // hit, buckets collide, the table fills up and tombstones pile up. A
    // small share is noise with every field drawn at random.
    task automatic test_random_traffic();
        logic [lpht_pkg::KEY_W-1:0]  pool_key [POOL_KEYS];
        int                          pool_len [POOL_KEYS];
        logic [lpht_pkg::KEY_W-1:0]  key;
        logic [lpht_pkg::KEY_W-1:0]  mask;
        logic [lpht_pkg::LEN_W-1:0]  len;
        logic [lpht_pkg::MODE_W-1:0] mode;
        int                          pick;
        int                          r;
        for (int op = 0; op < RANDOM_OPS; op++)
        begin
            if (op % SEGMENT_OPS == 0)
            begin
                // New key pool and a new idle pattern for each segment; some
                // segments run with no idling on one or both sides.
                for (int p = 0; p < POOL_KEYS; p++)
                begin
                    pool_key[p] = {$urandom, $urandom};
                    pool_len[p] = $urandom_range(0, lpht_pkg::KEY_MAX_BYTES);
                end
                sender_no_idle   = ($urandom_range(0, 3) == 0);
                receiver_no_idle = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, POOL_KEYS - 1);
            mask = key_mask(pool_len[pick]);
            // Bytes above the length are fresh garbage on every use.
            key  = (pool_key[pick] & mask) | ({$urandom, $urandom} & ~mask);
            len  = lpht_pkg::LEN_W'(pool_len[pick]);
            if (pool_len[pick] == lpht_pkg::KEY_MAX_BYTES && $urandom_range(0, 3) == 0)
                len = lpht_pkg::LEN_W'($urandom_range(lpht_pkg::KEY_MAX_BYTES + 1, 15));
            r = $urandom_range(0, 99);
            if (r < 36)
                mode = lpht_pkg::MODE_INSERT;
            else if (r < 64)
                mode = lpht_pkg::MODE_FIND;
            else if (r < 76)
                mode = lpht_pkg::MODE_ERASE_CLR;
            else if (r < 88)
                mode = lpht_pkg::MODE_ERASE_TOMB;
            else if (r < 91)
                mode = lpht_pkg::MODE_CLEAR;
            else if (r < 94)
                mode = lpht_pkg::MODE_W'($urandom_range(5, 7));
            else
            begin
                mode = lpht_pkg::MODE_W'($urandom_range(0, 7));
                key  = {$urandom, $urandom};
                len  = lpht_pkg::LEN_W'($urandom_range(0, 15));
            end
            offer_operation(mode, key, len);
        end
        sender_no_idle   = 1'b0;
        receiver_no_idle = 1'b0;
    endtask

    // Receiver side: a random stall before each result word, or one long
    // hold-off when a test asks for it, counted here in cycles.
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = receiver_no_idle ? 0 : $urandom_range(0, 19);
            if (hold_off_cycles > 0)
            begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Result checker: every word taken from the block is matched against the
    // oldest pending expectation, field by field.
    always @(posedge clk)
    begin
        table_result_t got;
        table_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[4:0];
            if (expected_results.size() == 0)
            begin
                note_mismatch("unexpected result word, status", -1, int'(got.status));
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status != want.status)
                    note_mismatch("status", int'(want.status), int'(got.status));
                if (got.slot != want.slot)
                    note_mismatch("slot_index", int'(want.slot), int'(got.slot));
            end
        end
    end

    // Hard limit on the whole run, several times the slowest correct run.
    initial
    begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int waited;
        for (int n = 0; n < SLOTS; n++)
            shadow_tag[n] = lpht_pkg::TAG_EMPTY;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_key_extremes();
        test_fill_and_full();
        test_output_backpressure();
        test_random_traffic();

        s_tvalid <= 1'b0;
        // Wait for all pending results, then a little longer to catch any
        // extra word the block might still produce.
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_cell.sv
hw/rtl/lpht_hash.sv
hw/rtl/linear_probe_hash_table.sv
hw/rtl/lpht_checker.sv
verif/linear_probe_hash_table_test.sv
